// ----- src/mi3_pkg.sv -----
// Shared types, constants and helpers for the 3x3 / 2x2 matrix inverse pipeline.
// No dependencies; every other file except mi3_if imports this package.
package mi3_pkg;

  localparam int SW   = 64;
  localparam int LIMB = 32;
  localparam int QW   = 62;

  typedef logic signed [SW-1:0] sw_t;
  typedef logic [3:0]           eidx_t;

  localparam sw_t CLAMP_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam sw_t CLAMP_MIN = 64'shC000_0000_0000_0000;

  // Element indices (row * 3 + column) of a*b - c*d for each adjugate entry.
  localparam eidx_t MINOR_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5},
    '{4'd1, 4'd8, 4'd7, 4'd2},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd3, 4'd8, 4'd6, 4'd5},
    '{4'd0, 4'd8, 4'd6, 4'd2},
    '{4'd0, 4'd5, 4'd3, 4'd2},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd0, 4'd7, 4'd6, 4'd1},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  // Adjugate entries that take the negated minor.
  localparam logic [8:0] COF_NEG  = 9'b010101010;
  // Entries that are live in 2x2 mode.
  localparam logic [8:0] LANE_2X2 = 9'b000011011;

  typedef struct packed {
    logic      func;
    sw_t [8:0] cof;
    sw_t       det2;
    sw_t       part;
  } ctx_t;

  function automatic sw_t clamp62(input sw_t v);
    sw_t r;
    if (v > CLAMP_MAX) begin
      r = CLAMP_MAX;
    end else if (v < CLAMP_MIN) begin
      r = CLAMP_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/mi3_if.sv -----
// Channel interfaces of the matrix inverse block: input matrix, result, threshold write.
// Depends on nothing; the element width is an interface parameter.
interface mi3_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic                func;
  logic signed [W-1:0] in_r0c0, in_r0c1, in_r0c2;
  logic signed [W-1:0] in_r1c0, in_r1c1, in_r1c2;
  logic signed [W-1:0] in_r2c0, in_r2c1, in_r2c2;
  modport source (output valid, func, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1,
                  in_r1c2, in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink   (input valid, func, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1,
                  in_r1c2, in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface mi3_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic                invertible;
  logic signed [W-1:0] det_value;
  logic signed [W-1:0] out_r0c0, out_r0c1, out_r0c2;
  logic signed [W-1:0] out_r1c0, out_r1c1, out_r1c2;
  logic signed [W-1:0] out_r2c0, out_r2c1, out_r2c2;
  modport source (output valid, invertible, det_value, out_r0c0, out_r0c1, out_r0c2,
                  out_r1c0, out_r1c1, out_r1c2, out_r2c0, out_r2c1, out_r2c2,
                  input ready);
  modport sink   (input valid, invertible, det_value, out_r0c0, out_r0c1, out_r0c2,
                  out_r1c0, out_r1c1, out_r1c2, out_r2c0, out_r2c1, out_r2c2,
                  output ready);
endinterface

interface mi3_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] zero_threshold;
  modport source (output valid, zero_threshold, input ready);
  modport sink   (input valid, zero_threshold, output ready);
endinterface

// ----- src/matrix_inverse_3x3.sv -----
// Top level of the 3x3 / 2x2 fixed-point matrix inverse by adjugate and determinant.
// Depends on mi3_pkg, mi3_if, mi3_mulq and mi3_div.
//
//   channel | direction | carries
//   --------+-----------+----------------------------------------------
//   req     | in        | func and nine matrix elements
//   rsp     | out       | invertible, det_value, nine inverse elements
//   cfg     | in        | zero_threshold, always ready
//
// One transaction enters per cycle unless a stall on rsp backs up to req. The
// depth is set by the two multiply passes (minors, then determinant) and the
// divider, which resolves one quotient bit per stage.
// Every stage holds its own valid bit, so a stall on rsp lets empty stages fill.
// Reset (rst, synchronous) clears the valid bits and sets zero_threshold to 1.
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic       clk,
  input logic       rst,
  mi3_cfg_if.sink   cfg,
  mi3_in_if.sink    req,
  mi3_out_if.source rsp
);

  localparam int  E     = ELEM_WIDTH;
  localparam int  NS    = E + 11;
  localparam int  S_DV  = 10;
  localparam sw_t EMAX  = (sw_t'(1) <<< (E - 1)) - sw_t'(1);
  localparam sw_t EMIN  = -EMAX - sw_t'(1);

  logic [NS-1:0] v, adv;
  logic [15:0]   thr;

  always_comb begin
    adv[NS-1] = ~v[NS-1] | rsp.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = ~v[i] | adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= req.valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  assign req.ready = adv[0];
  assign rsp.valid = v[NS-1];
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd1;
    end else if (cfg.valid) begin
      thr <= cfg.zero_threshold;
    end
  end

  // Input register.
  logic signed [E-1:0] a0 [9];
  logic                func0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      func0 <= req.func;
      a0[0] <= req.in_r0c0;
      a0[1] <= req.in_r0c1;
      a0[2] <= req.in_r0c2;
      a0[3] <= req.in_r1c0;
      a0[4] <= req.in_r1c1;
      a0[5] <= req.in_r1c2;
      a0[6] <= req.in_r2c0;
      a0[7] <= req.in_r2c1;
      a0[8] <= req.in_r2c2;
    end
  end

  // First multiply pass: the eighteen element products of the nine minors.
  sw_t p1 [18];

  for (genvar k = 0; k < 18; k++) begin : g_mul1
    mi3_mulq #(.AW(E), .BW(E), .FRAC(FRAC_BITS)) u_mul (
      .clk (clk),
      .en  (adv[3:1]),
      .a   (a0[MINOR_IDX[k/2][(k%2)*2]]),
      .b   (a0[MINOR_IDX[k/2][(k%2)*2+1]]),
      .q   (p1[k])
    );
  end

  // Elements 0..4 and func ride alongside the multiplier.
  logic signed [E-1:0] ae [1:3][5];
  logic                fe [1:3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      fe[1] <= func0;
      for (int i = 0; i < 5; i++) ae[1][i] <= a0[i];
    end
    for (int s = 2; s <= 3; s++) begin
      if (adv[s]) begin
        fe[s] <= fe[s-1];
        for (int i = 0; i < 5; i++) ae[s][i] <= ae[s-1][i];
      end
    end
  end

  // Minors and adjugate entries.
  ctx_t                ctx [4:9];
  logic signed [E-1:0] e4 [3];
  sw_t                 mn [9];
  sw_t [8:0]           c3, c2;
  sw_t                 p8;

  always_comb begin
    for (int m = 0; m < 9; m++) begin
      mn[m] = clamp62(p1[2*m] - p1[2*m+1]);
      c3[m] = COF_NEG[m] ? -mn[m] : mn[m];
    end
    c2    = '0;
    c2[0] = sw_t'(ae[3][4]);
    c2[1] = -sw_t'(ae[3][1]);
    c2[3] = -sw_t'(ae[3][3]);
    c2[4] = sw_t'(ae[3][0]);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ctx[4].func <= fe[3];
      ctx[4].cof  <= fe[3] ? c2 : c3;
      ctx[4].det2 <= mn[8];
      ctx[4].part <= '0;
      for (int i = 0; i < 3; i++) e4[i] <= ae[3][i];
    end
  end

  // Second multiply pass: row 0 against its cofactors.
  sw_t p2 [3];

  for (genvar j = 0; j < 3; j++) begin : g_mul2
    mi3_mulq #(.AW(E), .BW(SW), .FRAC(FRAC_BITS)) u_mul (
      .clk (clk),
      .en  (adv[7:5]),
      .a   (e4[j]),
      .b   (ctx[4].cof[j*3]),
      .q   (p2[j])
    );
  end

  always_ff @(posedge clk) begin
    for (int s = 5; s <= 7; s++) begin
      if (adv[s]) ctx[s] <= ctx[s-1];
    end
    if (adv[8]) begin
      ctx[8].func <= ctx[7].func;
      ctx[8].cof  <= ctx[7].cof;
      ctx[8].det2 <= ctx[7].det2;
      ctx[8].part <= clamp62(p2[0] + p2[1]);
      p8          <= p2[2];
    end
    if (adv[9]) begin
      ctx[9].func <= ctx[8].func;
      ctx[9].cof  <= ctx[8].cof;
      ctx[9].det2 <= ctx[8].det2;
      ctx[9].part <= ctx[8].func ? ctx[8].det2 : clamp62(ctx[8].part + p8);
    end
  end

  // Singularity test and determinant saturation, then the divider.
  sw_t                 det, det_mag;
  logic                ok;
  logic [8:0]          lanes;
  logic signed [E-1:0] det_sat;

  always_comb begin
    det     = ctx[9].part;
    det_mag = det[SW-1] ? -det : det;
    ok      = det_mag > sw_t'({48'b0, thr});
    lanes   = ok ? (ctx[9].func ? LANE_2X2 : 9'h1FF) : 9'h000;
    if (det > EMAX) begin
      det_sat = E'(EMAX);
    end else if (det < EMIN) begin
      det_sat = E'(EMIN);
    end else begin
      det_sat = E'(det);
    end
  end

  logic                okd  [S_DV:NS-1];
  logic signed [E-1:0] detd [S_DV:NS-1];

  always_ff @(posedge clk) begin
    if (adv[S_DV]) begin
      okd[S_DV]  <= ok;
      detd[S_DV] <= det_sat;
    end
    for (int s = S_DV + 1; s < NS; s++) begin
      if (adv[s]) begin
        okd[s]  <= okd[s-1];
        detd[s] <= detd[s-1];
      end
    end
  end

  logic [8:0][E-1:0] res;

  mi3_div #(.EW(E), .FRAC(FRAC_BITS)) u_div (
    .clk    (clk),
    .en     (adv[NS-1:S_DV]),
    .active (lanes),
    .num    (ctx[9].cof),
    .den    (det),
    .res    (res)
  );

  assign rsp.invertible = okd[NS-1];
  assign rsp.det_value  = detd[NS-1];
  assign rsp.out_r0c0   = $signed(res[0]);
  assign rsp.out_r0c1   = $signed(res[1]);
  assign rsp.out_r0c2   = $signed(res[2]);
  assign rsp.out_r1c0   = $signed(res[3]);
  assign rsp.out_r1c1   = $signed(res[4]);
  assign rsp.out_r1c2   = $signed(res[5]);
  assign rsp.out_r2c0   = $signed(res[6]);
  assign rsp.out_r2c1   = $signed(res[7]);
  assign rsp.out_r2c2   = $signed(res[8]);

endmodule

// ----- src/mi3_mulq.sv -----
// Three-stage signed fixed-point multiply: floor(a*b / 2^FRAC) clamped to 63-bit range.
// Depends on mi3_pkg. Wide operands are split into 32-bit limbs.
module mi3_mulq
  import mi3_pkg::*;
#(
  parameter int AW   = 32,
  parameter int BW   = 32,
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output sw_t                  q
);

  localparam int NA  = (AW + LIMB - 1) / LIMB;
  localparam int NB  = (BW + LIMB - 1) / LIMB;
  localparam int PW0 = (NA + NB) * LIMB;
  localparam int PW  = (PW0 > FRAC + QW + 1) ? PW0 : FRAC + QW + 1;

  logic signed [AW:0]     ax, amag;
  logic signed [BW:0]     bx, bmag;
  logic [NA*LIMB-1:0]     ma;
  logic [NB*LIMB-1:0]     mb;
  logic [2*LIMB-1:0]      pp [NA][NB];
  logic                   neg1, neg2;
  logic [PW-1:0]          sum, p;
  logic                   sat, rem;
  logic [QW-1:0]          qm;

  always_comb begin
    ax   = {a[AW-1], a};
    bx   = {b[BW-1], b};
    amag = ax[AW] ? -ax : ax;
    bmag = bx[BW] ? -bx : bx;
    ma   = (NA*LIMB)'($unsigned(amag));
    mb   = (NB*LIMB)'($unsigned(bmag));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= (2*LIMB)'(ma[i*LIMB +: LIMB]) * (2*LIMB)'(mb[j*LIMB +: LIMB]);
        end
      end
      neg1 <= a[AW-1] ^ b[BW-1];
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp[i][j]) << (LIMB * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p    <= sum;
      neg2 <= neg1;
    end
  end

  always_comb begin
    sat = |p[PW-1:FRAC+QW];
    qm  = p[FRAC+QW-1:FRAC];
    rem = |p[FRAC-1:0];
  end

  // Negative products round toward minus infinity, so a nonzero remainder adds one.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (sat) begin
        q <= neg2 ? CLAMP_MIN : CLAMP_MAX;
      end else if (neg2) begin
        q <= -(sw_t'({2'b00, qm}) + sw_t'({63'b0, rem}));
      end else begin
        q <= sw_t'({2'b00, qm});
      end
    end
  end

endmodule

// ----- src/mi3_div.sv -----
// Pipelined restoring divider for nine lanes: num*2^FRAC / den, truncated, saturated.
// Depends on mi3_pkg. One setup stage, EW-1 quotient-bit stages, one output stage.
module mi3_div
  import mi3_pkg::*;
#(
  parameter int EW   = 32,
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic [EW:0]          en,
  input  logic [8:0]           active,
  input  sw_t [8:0]            num,
  input  sw_t                  den,
  output logic [8:0][EW-1:0]   res
);

  localparam int K  = EW - 1;
  localparam int CW = SW + FRAC + EW;

  logic [SW-1:0] r   [EW][9];
  logic [K-1:0]  lo  [EW][9];
  logic [K-1:0]  qt  [EW][9];
  logic [8:0]    act [EW];
  logic [8:0]    neg [EW];
  logic [8:0]    ovf [EW];
  logic [SW-1:0] d   [EW];

  logic [SW-1:0] nm [9];
  logic [CW-1:0] nsh [9];
  logic [SW-1:0] dm;
  logic [CW-1:0] dsh;

  always_comb begin
    dm  = den[SW-1] ? SW'(-den) : SW'(den);
    dsh = CW'(dm) << K;
    for (int l = 0; l < 9; l++) begin
      nm[l]  = num[l][SW-1] ? SW'(-num[l]) : SW'(num[l]);
      nsh[l] = CW'(nm[l]) << FRAC;
    end
  end

  // A quotient of 2^K or more saturates; otherwise the top of the dividend is below den.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d[0]   <= dm;
      act[0] <= active;
      for (int l = 0; l < 9; l++) begin
        r[0][l]   <= nsh[l][K +: SW];
        lo[0][l]  <= nsh[l][K-1:0];
        qt[0][l]  <= '0;
        ovf[0][l] <= nsh[l] >= dsh;
        neg[0][l] <= num[l][SW-1] ^ den[SW-1];
      end
    end
  end

  for (genvar k = 1; k <= K; k++) begin : g_step
    logic [SW-1:0] t [9];

    always_comb begin
      for (int l = 0; l < 9; l++) begin
        t[l] = {r[k-1][l][SW-2:0], lo[k-1][l][K-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        d[k]   <= d[k-1];
        act[k] <= act[k-1];
        neg[k] <= neg[k-1];
        ovf[k] <= ovf[k-1];
        for (int l = 0; l < 9; l++) begin
          lo[k][l] <= lo[k-1][l] << 1;
          if (t[l] >= d[k-1]) begin
            r[k][l]  <= t[l] - d[k-1];
            qt[k][l] <= {qt[k-1][l][K-2:0], 1'b1};
          end else begin
            r[k][l]  <= t[l];
            qt[k][l] <= {qt[k-1][l][K-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[EW]) begin
      for (int l = 0; l < 9; l++) begin
        if (!act[K][l]) begin
          res[l] <= '0;
        end else if (ovf[K][l]) begin
          res[l] <= neg[K][l] ? {1'b1, {K{1'b0}}} : {1'b0, {K{1'b1}}};
        end else if (neg[K][l]) begin
          res[l] <= EW'(0) - {1'b0, qt[K][l]};
        end else begin
          res[l] <= {1'b0, qt[K][l]};
        end
      end
    end
  end

endmodule
